// ===== hw/rtl/alr_pkg.sv =====
package alr_pkg;

    localparam int FADE_W     = 10;
    localparam int FADE_RESET = 100;

    typedef logic [1:0] action_t;
    typedef logic [1:0] mode_t;
    typedef logic [1:0] cfg_index_t;

    localparam action_t ACT_SAMPLE = 2'd0;
    localparam action_t ACT_MODE   = 2'd1;
    localparam action_t ACT_POS    = 2'd2;

    localparam mode_t MODE_RECORD = 2'd0;
    localparam mode_t MODE_PLAY   = 2'd1;
    localparam mode_t MODE_ONCE   = 2'd2;

    localparam cfg_index_t CFG_LOOP_LENGTH = 2'd0;
    localparam cfg_index_t CFG_FADE_LENGTH = 2'd1;
    localparam cfg_index_t CFG_BYPASS      = 2'd2;

endpackage

// ===== hw/rtl/alr_if.sv =====
interface alr_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int POS_W       = 16
);
    import alr_pkg::*;

    logic                          valid;
    logic                          ready;
    action_t                       action;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    mode_t                         new_mode;
    logic        [POS_W-1:0]       new_position;

    modport source (output valid, output action, output sample_in, output new_mode,
                    output new_position, input ready);
    modport sink   (input valid, input action, input sample_in, input new_mode,
                    input new_position, output ready);
endinterface

interface alr_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int POS_W       = 16
);
    import alr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    mode_t                         mode_now;
    logic        [POS_W-1:0]       position_now;

    modport source (output valid, output sample_out, output mode_now, output position_now,
                    input ready);
    modport sink   (input valid, input sample_out, input mode_now, input position_now,
                    output ready);
endinterface

// ===== hw/rtl/alr_blend.sv =====
module alr_blend #(
    parameter int MAG_W  = 17,
    parameter int FADE_W = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [MAG_W-1:0]          mag,
    input  logic [FADE_W-1:0]         fade,
    input  logic [FADE_W-1:0]         divisor,
    output logic                      done,
    output logic [MAG_W+FADE_W-1:0]   quot
);

    localparam int PW    = MAG_W + FADE_W;
    localparam int CNT_W = $clog2(PW + 1);

    typedef enum logic [2:0] {
        BL_IDLE = 3'b001,
        BL_MUL  = 3'b010,
        BL_DIV  = 3'b100
    } bl_state_t;

    bl_state_t           st_reg;
    bl_state_t           st_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                done_reg;
    logic [PW-1:0]       work_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [FADE_W-1:0]   fade_reg;
    logic [FADE_W-1:0]   div_reg;
    logic [FADE_W-1:0]   rem_reg;

    logic [PW-1:0]       mul_sum;
    logic [FADE_W:0]     rem_shift;
    logic [FADE_W:0]     rem_sub;
    logic                rem_ge;

    assign mul_sum   = {work_reg[PW-2:0], 1'b0}
                     + (fade_reg[FADE_W-1] ? PW'(mag_reg) : PW'(0));
    assign rem_shift = {rem_reg, work_reg[PW-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};
    assign rem_sub   = rem_shift - {1'b0, div_reg};

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        case (st_reg)
            BL_IDLE:
            begin
                if (start)
                begin
                    st_next  = BL_MUL;
                    cnt_next = CNT_W'(FADE_W);
                end
            end
            BL_MUL:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    st_next  = BL_DIV;
                    cnt_next = CNT_W'(PW);
                end
            end
            BL_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    st_next = BL_IDLE;
                end
            end
            default:
            begin
                st_next = BL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BL_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= (st_reg == BL_DIV) && (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            BL_IDLE:
            begin
                if (start)
                begin
                    work_reg <= '0;
                    mag_reg  <= mag;
                    fade_reg <= fade;
                    div_reg  <= divisor;
                    rem_reg  <= '0;
                end
            end
            BL_MUL:
            begin
                work_reg <= mul_sum;
                fade_reg <= {fade_reg[FADE_W-2:0], 1'b0};
            end
            BL_DIV:
            begin
                rem_reg  <= rem_ge ? rem_sub[FADE_W-1:0] : rem_shift[FADE_W-1:0];
                work_reg <= {work_reg[PW-2:0], rem_ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

// ===== hw/rtl/audio_loop_recorder.sv =====
// Audio looper with a record/play crossfade over a circular loop memory of MAX_LOOP
// samples. After reset the block sweeps the memory to zero, one entry per cycle, and
// accepts no item until the sweep is done; configuration writes are taken at any time.
// Control items (set mode, set position) act as they are accepted. A bypassed
// sample goes from idle straight to the write state and reaches the output register
// from there once that register is free. A blended sample passes the read, calc and
// write states; in calc the serial unit forms the blend term one bit per cycle: a
// shift-add multiply by the fade count, then one restoring-divide step per product bit.
// A new item is accepted while a finished result still waits in the output register.
module audio_loop_recorder #(
    parameter int MAX_LOOP    = 65536,
    parameter int SAMPLE_BITS = 16,
    localparam int POS_W = $clog2(MAX_LOOP),
    localparam int LEN_W = $clog2(MAX_LOOP + 1),
    localparam int CFG_W = (LEN_W > alr_pkg::FADE_W) ? LEN_W : alr_pkg::FADE_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    alr_in_if.sink                in_ch,
    alr_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  alr_pkg::cfg_index_t   cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);
    import alr_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int MAG_W = SB + 1;
    localparam int PW    = MAG_W + FADE_W;
    localparam int SUM_W = PW + 2;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CALC  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [POS_W-1:0]    clr_reg;
    logic [POS_W-1:0]    pos_reg;
    mode_t               mode_reg;
    logic [FADE_W-1:0]   fade_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [FADE_W-1:0]   flen_reg;
    logic                bypass_reg;
    logic                out_valid_reg;

    logic [SB-1:0]       s_reg;
    logic                byp_item_reg;
    logic [POS_W-1:0]    addr_reg;
    logic [SB-1:0]       mem_q;
    logic                neg_reg;
    logic [SB-1:0]       out_sample_reg;
    mode_t               out_mode_reg;
    logic [POS_W-1:0]    out_pos_reg;

    logic [SB-1:0]       mem [MAX_LOOP];

    logic                accept;
    logic                is_sample;
    logic                out_free;
    logic                commit;
    logic [POS_W-1:0]    rd_addr;
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]    diff_mag;
    logic                blend_done;
    logic [PW-1:0]       blend_quot;
    logic [SUM_W-1:0]    old_ext;
    logic [SUM_W-1:0]    q_ext;
    logic [SUM_W-1:0]    sum;
    logic                ovf;
    logic [SB-1:0]       blend_val;
    logic [LEN_W-1:0]    pos_inc;
    logic                pos_wrap;
    logic [POS_W-1:0]    pos_new;
    mode_t               mode_new;
    logic [FADE_W-1:0]   fade_new;
    logic                mem_we;
    logic [POS_W-1:0]    mem_wa;
    logic [SB-1:0]       mem_wd;
    logic [LEN_W-1:0]    len_raw;
    logic [FADE_W-1:0]   flen_raw;

    assign accept    = in_ch.valid && in_ch.ready;
    assign is_sample = accept && (in_ch.action == ACT_SAMPLE);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign commit    = (state_reg == ST_WRITE) && out_free;

    assign rd_addr = (LEN_W'(pos_reg) < len_reg) ? pos_reg : '0;

    assign diff     = $signed({s_reg[SB-1], s_reg}) - $signed({mem_q[SB-1], mem_q});
    assign diff_mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    assign old_ext   = {{(SUM_W-SB){mem_q[SB-1]}}, mem_q};
    assign q_ext     = {2'b00, blend_quot};
    assign sum       = neg_reg ? (old_ext - q_ext) : (old_ext + q_ext);
    assign ovf       = !((&sum[SUM_W-1:SB-1]) || !(|sum[SUM_W-1:SB-1]));
    assign blend_val = ovf ? (sum[SUM_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}})
                           : sum[SB-1:0];

    assign pos_inc  = LEN_W'(addr_reg) + LEN_W'(1);
    assign pos_wrap = pos_inc >= len_reg;
    assign pos_new  = pos_wrap ? '0 : pos_inc[POS_W-1:0];
    assign mode_new = ((mode_reg == MODE_ONCE) && pos_wrap) ? MODE_PLAY : mode_reg;

    always_comb
    begin
        fade_new = fade_reg;
        if (mode_reg == MODE_PLAY)
        begin
            if (fade_reg != '0)
            begin
                fade_new = fade_reg - FADE_W'(1);
            end
        end
        else if (fade_reg < flen_reg)
        begin
            fade_new = fade_reg + FADE_W'(1);
        end
    end

    alr_blend #(
        .MAG_W  (MAG_W),
        .FADE_W (FADE_W)
    ) u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_READ),
        .mag     (diff_mag),
        .fade    (fade_reg),
        .divisor (flen_reg),
        .done    (blend_done),
        .quot    (blend_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == POS_W'(MAX_LOOP - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (is_sample)
                begin
                    state_next = bypass_reg ? ST_WRITE : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (blend_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_we = (state_reg == ST_CLEAR) || (commit && !byp_item_reg);
    assign mem_wa = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;
    assign mem_wd = (state_reg == ST_CLEAR) ? '0 : blend_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    assign len_raw  = cfg_data[LEN_W-1:0];
    assign flen_raw = cfg_data[FADE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            mode_reg      <= MODE_RECORD;
            fade_reg      <= '0;
            len_reg       <= LEN_W'(MAX_LOOP);
            flen_reg      <= FADE_W'(FADE_RESET);
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + POS_W'(1);
            end
            if (accept && (in_ch.action == ACT_MODE) && (in_ch.new_mode <= MODE_ONCE))
            begin
                mode_reg <= in_ch.new_mode;
            end
            if (accept && (in_ch.action == ACT_POS)
                && (LEN_W'(in_ch.new_position) < len_reg))
            begin
                pos_reg <= in_ch.new_position;
            end
            if (commit && !byp_item_reg)
            begin
                fade_reg <= fade_new;
                pos_reg  <= pos_new;
                mode_reg <= mode_new;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOOP_LENGTH:
                    begin
                        if (len_raw == '0)
                        begin
                            len_reg <= LEN_W'(1);
                        end
                        else if (len_raw > LEN_W'(MAX_LOOP))
                        begin
                            len_reg <= LEN_W'(MAX_LOOP);
                        end
                        else
                        begin
                            len_reg <= len_raw;
                        end
                        pos_reg <= '0;
                    end
                    CFG_FADE_LENGTH:
                    begin
                        flen_reg <= (flen_raw == '0) ? FADE_W'(1) : flen_raw;
                    end
                    CFG_BYPASS:
                    begin
                        bypass_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        bypass_reg <= bypass_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            s_reg        <= in_ch.sample_in;
            byp_item_reg <= bypass_reg;
            addr_reg     <= rd_addr;
        end
        if (state_reg == ST_READ)
        begin
            neg_reg <= diff[MAG_W-1];
        end
        if (commit)
        begin
            if (byp_item_reg)
            begin
                out_sample_reg <= s_reg;
                out_mode_reg   <= mode_reg;
                out_pos_reg    <= pos_reg;
            end
            else
            begin
                out_sample_reg <= blend_val;
                out_mode_reg   <= mode_new;
                out_pos_reg    <= pos_new;
            end
        end
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_out   = out_sample_reg;
    assign out_ch.mode_now     = out_mode_reg;
    assign out_ch.position_now = out_pos_reg;

endmodule

// ===== verif/tb.sv =====
module tb;
    import alr_pkg::*;

    localparam int      CYCLE_LIMIT = 1000000;
    localparam int      DRAIN_WAIT  = 64;
    localparam action_t ACT_UNUSED  = 2'd3;
    localparam mode_t   MODE_UNUSED = 2'd3;

    typedef struct {
        action_t     action;
        logic [15:0] sample_in;
        mode_t       new_mode;
        logic [15:0] new_position;
        bit          drain;
    } feed_item_t;

    typedef struct {
        logic [15:0] sample_out;
        mode_t       mode_now;
        logic [15:0] position_now;
    } looper_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [16:0] cfg_data;

    alr_in_if  #(.SAMPLE_BITS(16), .POS_W(16)) in_ch ();
    alr_out_if #(.SAMPLE_BITS(16), .POS_W(16)) out_ch ();

    audio_loop_recorder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    feed_item_t  item_feed[$];
    looper_out_t sample_out_q[$];
    feed_item_t  drv_item;
    bit          item_sent = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          cycle_cnt = 0;
    int          err_count = 0;
    int          stall_style = 0;
    int          stall_hold = 0;
    int          gen_len = 65536;

    // Mirror of the looper state and its registers.
    shortint     m_mem [0:65535];
    logic [16:0] m_loop_len = 17'd65536;
    logic [9:0]  m_fade_len = 10'(FADE_RESET);
    bit          m_bypass = 1'b0;
    logic [15:0] m_pos = '0;
    mode_t       m_mode = MODE_RECORD;
    logic [9:0]  m_fade_cnt = '0;

    task automatic report_mismatch(string msg);
        $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
        err_count++;
    endtask

    task automatic looper_step(feed_item_t it);
        int          len;
        int          flen;
        int          pos;
        int          fc;
        longint      old_v;
        longint      in_v;
        longint      blend;
        looper_out_t r;
        len  = (m_loop_len == 0) ? 1 : ((m_loop_len > 65536) ? 65536 : int'(m_loop_len));
        flen = (m_fade_len == 0) ? 1 : int'(m_fade_len);
        if (it.action == ACT_MODE) begin
            if (it.new_mode <= MODE_ONCE)
                m_mode = it.new_mode;
        end else if (it.action == ACT_POS) begin
            if (int'(it.new_position) < len)
                m_pos = it.new_position;
        end else if (it.action == ACT_SAMPLE) begin
            if (m_bypass) begin
                r.sample_out = it.sample_in;
            end else begin
                pos = m_pos;
                if (pos >= len)
                    pos = 0;
                fc    = m_fade_cnt;
                in_v  = longint'($signed(it.sample_in));
                old_v = m_mem[pos];
                blend = old_v + ((in_v - old_v) * fc) / flen;
                if (blend > 32767)
                    blend = 32767;
                else if (blend < -32768)
                    blend = -32768;
                m_mem[pos] = shortint'(blend);
                if (m_mode == MODE_PLAY) begin
                    if (m_fade_cnt > 0)
                        m_fade_cnt--;
                end else if (fc < flen) begin
                    m_fade_cnt++;
                end
                pos++;
                if (pos >= len)
                    pos = 0;
                m_pos = pos[15:0];
                if (m_mode == MODE_ONCE && pos == 0)
                    m_mode = MODE_PLAY;
                r.sample_out = blend[15:0];
            end
            r.mode_now     = m_mode;
            r.position_now = m_pos;
            sample_out_q.push_back(r);
        end
    endtask

    // The value lands in the field that the action uses; the rest is noise.
    task automatic add_item(action_t a, logic [15:0] v, bit drain = 1'b0);
        feed_item_t it;
        it.action       = a;
        it.sample_in    = 16'($urandom);
        it.new_mode     = mode_t'($urandom);
        it.new_position = 16'($urandom);
        it.drain        = drain;
        if (a == ACT_SAMPLE)
            it.sample_in = v;
        else if (a == ACT_MODE)
            it.new_mode = v[1:0];
        else if (a == ACT_POS)
            it.new_position = v;
        item_feed.push_back(it);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic settle();
        while (item_feed.size() > 0 || in_ch.valid || sample_out_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [16:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LOOP_LENGTH) begin
            m_loop_len = val;
            m_pos      = '0;
        end else if (idx == CFG_FADE_LENGTH) begin
            m_fade_len = val[9:0];
        end else begin
            m_bypass = val[0];
        end
    endtask

    task automatic new_setting(logic [16:0] len, logic [9:0] fl, bit byp);
        settle();
        write_reg(CFG_LOOP_LENGTH, len);
        write_reg(CFG_FADE_LENGTH, 17'(fl));
        write_reg(CFG_BYPASS, 17'(byp));
        gen_len = (len == 0) ? 1 : ((len > 65536) ? 65536 : int'(len));
    endtask

    task automatic random_items(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                add_item(ACT_SAMPLE, pick_sample(), $urandom_range(0, 99) == 0);
            else if (r < 89)
                add_item(ACT_MODE, 16'($urandom_range(0, 3)));
            else if (r < 97) begin
                if ($urandom_range(0, 3) != 0)
                    add_item(ACT_POS, 16'($urandom_range(0, gen_len - 1)));
                else if (gen_len < 65536)
                    add_item(ACT_POS, 16'($urandom_range(gen_len, 65535)));
                else
                    add_item(ACT_POS, 16'($urandom));
            end else
                add_item(ACT_UNUSED, 16'($urandom));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            looper_step(drv_item);
            item_sent = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        logic nv;
        nv = 1'b0;
        if (rst_n && !(in_ch.valid && !item_sent)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (item_feed.size() > 0 &&
                         !(item_feed[0].drain && sample_out_q.size() > 0)) begin
                drv_item = item_feed.pop_front();
                in_ch.action       <= drv_item.action;
                in_ch.sample_in    <= drv_item.sample_in;
                in_ch.new_mode     <= drv_item.new_mode;
                in_ch.new_position <= drv_item.new_position;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            in_ch.valid <= nv;
            item_sent = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (cycle_cnt % 256 == 0)
            stall_style = $urandom_range(0, 3);
        case (stall_style)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= (cycle_cnt % 7) != 0;
            default:
            begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    out_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_hold = $urandom_range(5, 40);
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        looper_out_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (sample_out_q.size() == 0) begin
                report_mismatch("result arrived with no item outstanding");
            end else begin
                e = sample_out_q.pop_front();
                if (out_ch.sample_out !== e.sample_out)
                    report_mismatch($sformatf("sample_out %h, expected %h",
                                              out_ch.sample_out, e.sample_out));
                if (out_ch.mode_now !== e.mode_now)
                    report_mismatch($sformatf("mode_now %0d, expected %0d",
                                              out_ch.mode_now, e.mode_now));
                if (out_ch.position_now !== e.position_now)
                    report_mismatch($sformatf("position_now %0d, expected %0d",
                                              out_ch.position_now, e.position_now));
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_LOOP_LENGTH;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_SAMPLE;
        in_ch.sample_in    = '0;
        in_ch.new_mode     = MODE_RECORD;
        in_ch.new_position = '0;
        out_ch.ready       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers: extremes of the sample, all modes, wrap at the top index.
        add_item(ACT_SAMPLE, 16'h7FFF);
        add_item(ACT_SAMPLE, 16'h8000);
        add_item(ACT_SAMPLE, 16'h0000);
        add_item(ACT_MODE, 16'(MODE_UNUSED));
        add_item(ACT_UNUSED, 16'hFFFF);
        add_item(ACT_POS, 16'hFFFF);
        add_item(ACT_MODE, 16'(MODE_ONCE));
        add_item(ACT_SAMPLE, 16'h8000);
        add_item(ACT_SAMPLE, 16'h7FFF);
        add_item(ACT_MODE, 16'(MODE_RECORD));
        add_item(ACT_POS, 16'h0000);
        add_item(ACT_SAMPLE, 16'h7FFF, 1'b1);

        // Short loop: positions out of range and a record-once pass.
        new_setting(17'd4, 10'd1, 1'b0);
        add_item(ACT_POS, 16'd4);
        add_item(ACT_POS, 16'hFFFF);
        add_item(ACT_POS, 16'd3);
        add_item(ACT_MODE, 16'(MODE_ONCE));
        for (int i = 0; i < 5; i++)
            add_item(ACT_SAMPLE, pick_sample());

        // Bypass with zero lengths; control items still act.
        new_setting(17'd0, 10'd0, 1'b1);
        add_item(ACT_SAMPLE, 16'h5555);
        add_item(ACT_MODE, 16'(MODE_RECORD));
        add_item(ACT_POS, 16'd1);
        add_item(ACT_SAMPLE, 16'hAAAA);

        // Ramp the fade count high, then cut the fade length below it.
        new_setting(17'h1FFFF, 10'd1023, 1'b0);
        add_item(ACT_MODE, 16'(MODE_RECORD));
        for (int i = 0; i < 200; i++)
            add_item(ACT_SAMPLE, pick_sample());
        new_setting(17'd100, 10'd3, 1'b0);
        random_items(60);

        for (int k = 0; k < 10; k++) begin
            logic [16:0] len;
            logic [9:0]  fl;
            case ($urandom_range(0, 7))
                0:       len = 17'd1;
                1:       len = 17'd2;
                2:       len = 17'd3;
                3:       len = 17'd7;
                4:       len = 17'd64;
                5:       len = 17'd1000;
                6:       len = 17'd65536;
                default: len = 17'($urandom_range(0, 131071));
            endcase
            case ($urandom_range(0, 5))
                0:       fl = 10'd1;
                1:       fl = 10'd2;
                2:       fl = 10'd7;
                3:       fl = 10'd100;
                4:       fl = 10'd1023;
                default: fl = 10'($urandom_range(0, 1023));
            endcase
            if (k == 0) begin
                len = 17'd1;
                fl  = 10'd1;
            end else if (k == 1) begin
                len = 17'd65536;
                fl  = 10'd1023;
            end
            new_setting(len, fl, $urandom_range(0, 7) == 0);
            random_items(130);
        end

        settle();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/alr_pkg.sv
hw/rtl/alr_if.sv
hw/rtl/alr_blend.sv
hw/rtl/audio_loop_recorder.sv
verif/tb.sv
